[hw/rtl/kedh_pkg.sv]
// Shared types and constants for the held-key event decoder.
// Used by the front, queue, back and top level files; depends on nothing.
`default_nettype none

package kedh_pkg;

  // Default capacity of the held-key list.
  localparam int MAX_KEYS_DEF = 16;

  // Field widths of a remapped key position.
  localparam int X_W = 5;
  localparam int Y_W = 2;
  localparam int KEY_W = X_W + Y_W;

  // Event byte layout and key matrix geometry.
  localparam int PRESS_BIT = 7;
  localparam logic [6:0] CODE_MASK = 7'h7F;
  localparam int KEY_COLS = 10;

  // Division by ten as a multiply by 205 and a shift by 11, exact for the 7-bit code range.
  localparam int RECIP_10 = 205;
  localparam int RECIP_SHIFT = 11;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_ADDED     = 3'd0,
    ACT_HELD      = 3'd1,
    ACT_REMOVED   = 3'd2,
    ACT_NOT_HELD  = 3'd3,
    ACT_FULL      = 3'd4,
    ACT_IGNORED   = 3'd5,
    ACT_CLEARED   = 3'd6,
    ACT_READ      = 3'd7
  } act_t;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    cmd_t             cmd;
    logic             pressed;
    logic             zero_code;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [3:0]       idx;
  } item_t;

endpackage

`default_nettype wire

[hw/rtl/kedh_front.sv]
// Front stage: accepts input words, decodes the event byte into a key position.
// Depends on kedh_pkg; feeds kedh_fifo.
`default_nettype none

module kedh_front
  import kedh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_event_code,
  input  wire logic [3:0]  in_entry_index,
  output logic             push_valid,
  input  wire logic        push_ready,
  output item_t            push_item
);

  logic        stg_valid_r;
  logic        stg_valid_nxt;
  item_t       stg_item_r;
  item_t       dec_item;
  logic        accept;

  logic [6:0]  code;
  logic [6:0]  code_m1;
  logic [14:0] prod;
  logic [3:0]  row;
  logic [6:0]  row10;
  logic [6:0]  col_full;
  logic [3:0]  col;

  // Row is (code - 1) / 10 via reciprocal multiply; column is the remainder.
  always_comb begin
    code     = in_event_code[6:0] & CODE_MASK;
    code_m1  = code - 7'd1;
    prod     = 15'(code_m1) * 15'(RECIP_10);
    row      = prod[RECIP_SHIFT +: 4];
    row10    = 7'(row) * 7'(KEY_COLS);
    col_full = code_m1 - row10;
    col      = col_full[3:0];

    dec_item.cmd       = cmd_t'(in_command);
    dec_item.pressed   = in_event_code[PRESS_BIT];
    dec_item.zero_code = (code == 7'd0);
    dec_item.x         = {row, 1'b0} + X_W'(col > 4'd3);
    dec_item.y         = col[Y_W-1:0];
    dec_item.idx       = in_entry_index;
  end

  assign in_ready      = !stg_valid_r || push_ready;
  assign accept        = in_valid && in_ready;
  assign stg_valid_nxt = accept || (stg_valid_r && !push_ready);
  assign push_valid    = stg_valid_r;
  assign push_item     = stg_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
    if (accept) begin
      stg_item_r <= dec_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/kedh_fifo.sv]
// Short queue of decoded words between the front and the back.
// Depends on kedh_pkg for the word type and depth.
`default_nettype none

module kedh_fifo
  import kedh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);

  item_t          slot_r [Q_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [NW-1:0]  fill_r;
  logic [PW-1:0]  wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_nxt;
  logic [NW-1:0]  fill_nxt;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill_r != NW'(Q_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + NW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/kedh_back.sv]
// Back end: executes decoded words against the held-key list memory and
// registers the result word. Depends on kedh_pkg.
`default_nettype none

module kedh_back
  import kedh_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire item_t       q_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_action,
  output logic [4:0]       out_key_x,
  output logic [1:0]       out_key_y,
  output logic             out_pressed,
  output logic [4:0]       out_held_count,
  output logic             out_entry_valid
);

  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int IW = (CW > 4) ? CW : 4;
  localparam int HW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  // List memory: one word per entry, x in the upper bits and y in the lower.
  logic [KEY_W-1:0] mem [MAX_KEYS];
  logic [KEY_W-1:0] rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [KEY_W-1:0] mem_wd;
  logic [AW-1:0]    mem_ra;

  state_t           state_r, state_nxt;
  item_t            item_r, item_nxt;
  logic [CW-1:0]    total_r, total_nxt;
  logic [CW-1:0]    issue_r, issue_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [CW-1:0]    pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]    sh_wr_r, sh_wr_nxt;

  act_t             res_act_r, res_act_nxt;
  logic [X_W-1:0]   res_x_r, res_x_nxt;
  logic [Y_W-1:0]   res_y_r, res_y_nxt;
  logic             res_pressed_r, res_pressed_nxt;
  logic             res_valid_r, res_valid_nxt;

  logic             out_valid_r, out_valid_nxt;
  act_t             out_act_r, out_act_nxt;
  logic [X_W-1:0]   out_x_r, out_x_nxt;
  logic [Y_W-1:0]   out_y_r, out_y_nxt;
  logic             out_pr_r, out_pr_nxt;
  logic [4:0]       out_cnt_r, out_cnt_nxt;
  logic             out_ev_r, out_ev_nxt;

  logic [IW-1:0]    idx_w;
  logic [IW-1:0]    tot_i;
  logic [HW-1:0]    tot_h;
  logic [CW:0]      pend_p1;
  logic [CW:0]      sh_p2;
  logic             more;
  logic             hit;
  logic             miss_all;

  always_comb begin
    idx_w    = IW'(q_item.idx);
    tot_i    = IW'(total_r);
    tot_h    = HW'(total_r);
    pend_p1  = {1'b0, pend_idx_r} + (CW+1)'(1);
    sh_p2    = {1'b0, sh_wr_r} + (CW+1)'(2);
    more     = (issue_r < total_r);
    hit      = pend_vld_r && (rdata_r == {item_r.x, item_r.y});
    miss_all = !pend_vld_r && !more;
  end

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    total_nxt       = total_r;
    issue_nxt       = issue_r;
    pend_vld_nxt    = pend_vld_r;
    pend_idx_nxt    = pend_idx_r;
    sh_wr_nxt       = sh_wr_r;
    res_act_nxt     = res_act_r;
    res_x_nxt       = res_x_r;
    res_y_nxt       = res_y_r;
    res_pressed_nxt = res_pressed_r;
    res_valid_nxt   = res_valid_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_act_nxt     = out_act_r;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_pr_nxt      = out_pr_r;
    out_cnt_nxt     = out_cnt_r;
    out_ev_nxt      = out_ev_r;
    mem_we          = 1'b0;
    mem_wa          = total_r[AW-1:0];
    mem_wd          = {item_r.x, item_r.y};
    mem_ra          = '0;
    q_ready         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_ready         = 1'b1;
          item_nxt        = q_item;
          res_x_nxt       = '0;
          res_y_nxt       = '0;
          res_pressed_nxt = 1'b0;
          res_valid_nxt   = 1'b0;
          state_nxt       = ST_DONE;
          case (q_item.cmd)
            CMD_KEY: begin
              res_pressed_nxt = q_item.pressed;
              if (q_item.zero_code) begin
                res_act_nxt = ACT_IGNORED;
              end else begin
                res_x_nxt    = q_item.x;
                res_y_nxt    = q_item.y;
                issue_nxt    = '0;
                pend_vld_nxt = 1'b0;
                state_nxt    = ST_SEARCH;
              end
            end
            CMD_CLEAR: begin
              total_nxt   = '0;
              res_act_nxt = ACT_CLEARED;
            end
            CMD_READ: begin
              res_act_nxt = ACT_READ;
              if (idx_w < tot_i) begin
                mem_ra    = idx_w[AW-1:0];
                state_nxt = ST_RDWAIT;
              end
            end
            default: begin
              res_act_nxt = ACT_IGNORED;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        // One read issued per cycle; the compare sees the word read last cycle.
        if (more) begin
          mem_ra       = issue_r[AW-1:0];
          issue_nxt    = issue_r + CW'(1);
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = issue_r;
        end else begin
          pend_vld_nxt = 1'b0;
        end
        if (hit) begin
          if (item_r.pressed) begin
            res_act_nxt = ACT_HELD;
            state_nxt   = ST_DONE;
          end else if (pend_p1 < {1'b0, total_r}) begin
            mem_ra    = pend_p1[AW-1:0];
            sh_wr_nxt = pend_idx_r;
            state_nxt = ST_SHIFT;
          end else begin
            total_nxt   = total_r - CW'(1);
            res_act_nxt = ACT_REMOVED;
            state_nxt   = ST_DONE;
          end
        end else if (miss_all) begin
          state_nxt = ST_DONE;
          if (!item_r.pressed) begin
            res_act_nxt = ACT_NOT_HELD;
          end else if (total_r >= CW'(MAX_KEYS)) begin
            res_act_nxt = ACT_FULL;
          end else begin
            mem_we      = 1'b1;
            mem_wa      = total_r[AW-1:0];
            total_nxt   = total_r + CW'(1);
            res_act_nxt = ACT_ADDED;
          end
        end
      end

      ST_SHIFT: begin
        // Move entry w+1 down to w while fetching entry w+2.
        mem_we    = 1'b1;
        mem_wa    = sh_wr_r[AW-1:0];
        mem_wd    = rdata_r;
        sh_wr_nxt = sh_wr_r + CW'(1);
        if (sh_p2 < {1'b0, total_r}) begin
          mem_ra = sh_p2[AW-1:0];
        end else begin
          total_nxt   = total_r - CW'(1);
          res_act_nxt = ACT_REMOVED;
          state_nxt   = ST_DONE;
        end
      end

      ST_RDWAIT: begin
        res_x_nxt     = rdata_r[KEY_W-1:Y_W];
        res_y_nxt     = rdata_r[Y_W-1:0];
        res_valid_nxt = 1'b1;
        state_nxt     = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_act_nxt   = res_act_r;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          out_pr_nxt    = res_pressed_r;
          out_cnt_nxt   = tot_h[4:0];
          out_ev_nxt    = res_valid_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r        <= item_nxt;
    issue_r       <= issue_nxt;
    pend_idx_r    <= pend_idx_nxt;
    sh_wr_r       <= sh_wr_nxt;
    res_act_r     <= res_act_nxt;
    res_x_r       <= res_x_nxt;
    res_y_r       <= res_y_nxt;
    res_pressed_r <= res_pressed_nxt;
    res_valid_r   <= res_valid_nxt;
    out_act_r     <= out_act_nxt;
    out_x_r       <= out_x_nxt;
    out_y_r       <= out_y_nxt;
    out_pr_r      <= out_pr_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_ev_r      <= out_ev_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_act_r;
  assign out_key_x       = out_x_r;
  assign out_key_y       = out_y_r;
  assign out_pressed     = out_pr_r;
  assign out_held_count  = out_cnt_r;
  assign out_entry_valid = out_ev_r;

endmodule

`default_nettype wire

[hw/rtl/key_event_decode_held_set_top.sv]
// Top level of the held-key event decoder: front decoder, word queue, back end.
// Depends on kedh_pkg, kedh_front, kedh_fifo and kedh_back.
`default_nettype none

// This block tracks which keys of a keypad are held down. Every input word
// carries a command: a key event (the event byte has the press flag in bit 7
// and a 1-based key code in the low seven bits), a clear of the list, or a
// read of one list entry. A key code is split into row and column of a
// ten-column matrix and remapped to x = 2*row + (column > 3), y = column mod 4.
// A press appends the key to an ordered list if it is not there yet, a release
// removes it and closes the gap, and a key code of zero is ignored. When the
// list holds MAX_KEYS entries a new press is dropped and reported as such.
// Each input word yields exactly one result word, with the action taken, the
// key position, the press flag, the list length afterwards and, for a read,
// whether the index was inside the list. The front decodes and registers each
// word and hands it through a two-word queue to the back, so input words keep
// being accepted while the back is busy or a result waits to be taken, as long
// as the front register or the queue has room. The back works on one word at a
// time against a list memory with one read and one write port, reading one entry
// per cycle while it searches. A release stops searching at the entry it moves
// the rest down to, then moves each later entry down by one. A clear and a read
// outside the list go straight to the result; a read inside the list first waits
// for the memory word.
// The list memory needs no clearing after reset because only entries below
// the current length are ever used.

module key_event_decode_held_set_top
  import kedh_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_event_code,
  input  wire logic [3:0]  in_entry_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_action,
  output logic [4:0]       out_key_x,
  output logic [1:0]       out_key_y,
  output logic             out_pressed,
  output logic [4:0]       out_held_count,
  output logic             out_entry_valid
);

  // Decoded words from the front into the queue.
  logic  push_valid;
  logic  push_ready;
  item_t push_item;

  // Decoded words from the queue into the back.
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  kedh_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_event_code  (in_event_code),
    .in_entry_index (in_entry_index),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  kedh_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  kedh_back #(
    .MAX_KEYS (MAX_KEYS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_action      (out_action),
    .out_key_x       (out_key_x),
    .out_key_y       (out_key_y),
    .out_pressed     (out_pressed),
    .out_held_count  (out_held_count),
    .out_entry_valid (out_entry_valid)
  );

endmodule

`default_nettype wire

[sim/tb_key_event_decode_held_set_top.sv]
// Self-checking testbench for the held-key event decoder (key_event_decode_held_set_top).
// Depends on kedh_pkg for the command and action codes and on the RTL top level only.
// A behavioral held-key list predicts every result word; directed and random words follow.

module tb_key_event_decode_held_set_top
  import kedh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Capacity of the held-key list in the instance under test.
  localparam int LIST_DEPTH = MAX_KEYS_DEF;
  // Cycles without any accepted word on either channel before the run is abandoned.
  // The slowest word is a key event that searches or shifts through the whole list in the
  // back end, and the random stalls on both sides are short, so this leaves a wide margin.
  localparam int STALL_LIMIT = 4000;
  // Quiet cycles after the last result, enough for the longest search and shift.
  localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
  // Mismatch lines printed before the report goes silent and only counts.
  localparam int REPORT_CAP = 40;

  // One result word, laid out field by field as it leaves the block.
  typedef struct packed {
    act_t             action;
    logic [X_W-1:0]   key_x;
    logic [Y_W-1:0]   key_y;
    logic             pressed;
    logic [4:0]       count;
    logic             entry_valid;
  } key_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = '0;
  logic [7:0]  in_event_code = '0;
  logic [3:0]  in_entry_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_action;
  logic [4:0]  out_key_x;
  logic [1:0]  out_key_y;
  logic        out_pressed;
  logic [4:0]  out_held_count;
  logic        out_entry_valid;

  // Predicted copy of the held-key list, updated as each input word is accepted.
  logic [X_W-1:0] list_x [LIST_DEPTH];
  logic [Y_W-1:0] list_y [LIST_DEPTH];
  int             list_len = 0;

  // Result words predicted but not yet seen on the output, oldest first.
  key_result_t    pending_results[$];

  // Idling of both sides in percent: of words sent after a gap, and of cycles with ready low.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  int mismatch_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int reads_in_list = 0;
  int action_seen [8];
  int quiet_cycles = 0;

  key_event_decode_held_set_top #(
    .MAX_KEYS(LIST_DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_event_code  (in_event_code),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_key_x      (out_key_x),
    .out_key_y      (out_key_y),
    .out_pressed    (out_pressed),
    .out_held_count (out_held_count),
    .out_entry_valid(out_entry_valid)
  );

  always #5 clk = ~clk;

  // Applies one accepted input word to the predicted list and returns the result
  // word the block must produce for it. A key code is split into row and column
  // of a ten-column matrix; columns above three move to the odd x, and columns
  // eight and nine therefore alias columns four and five of the same row.
  function automatic key_result_t track_word(cmd_t cmd, logic [7:0] ev, logic [3:0] idx);
    key_result_t    r;
    int             code;
    int             row;
    int             col;
    int             pos;
    logic [X_W-1:0] kx;
    logic [Y_W-1:0] ky;
    r = '0;
    case (cmd)
      CMD_KEY: begin
        r.pressed = ev[PRESS_BIT];
        code = int'(ev[6:0]);
        if (code == 0) begin
          // A zero key code has no matrix position and leaves the list alone.
          r.action = ACT_IGNORED;
        end else begin
          row = (code - 1) / KEY_COLS;
          col = (code - 1) % KEY_COLS;
          kx = X_W'(2 * row + ((col > 3) ? 1 : 0));
          ky = Y_W'(col % 4);
          r.key_x = kx;
          r.key_y = ky;
          pos = -1;
          for (int i = 0; i < list_len; i++) begin
            if (pos < 0 && list_x[i] == kx && list_y[i] == ky) pos = i;
          end
          if (ev[PRESS_BIT]) begin
            // A held key wins over a full list: it is reported as held, not dropped.
            if (pos >= 0) begin
              r.action = ACT_HELD;
            end else if (list_len >= LIST_DEPTH) begin
              r.action = ACT_FULL;
            end else begin
              list_x[list_len] = kx;
              list_y[list_len] = ky;
              list_len++;
              r.action = ACT_ADDED;
            end
          end else if (pos >= 0) begin
            // Release closes the gap so the list keeps press order.
            for (int i = pos; i < list_len - 1; i++) begin
              list_x[i] = list_x[i + 1];
              list_y[i] = list_y[i + 1];
            end
            list_len--;
            r.action = ACT_REMOVED;
          end else begin
            r.action = ACT_NOT_HELD;
          end
        end
      end
      CMD_CLEAR: begin
        list_len = 0;
        r.action = ACT_CLEARED;
      end
      CMD_READ: begin
        r.action = ACT_READ;
        if (int'(idx) < list_len) begin
          r.key_x = list_x[idx];
          r.key_y = list_y[idx];
          r.entry_valid = 1'b1;
        end
      end
      default: begin
        // The spare command is a no-op that still answers with one word.
        r.action = ACT_IGNORED;
      end
    endcase
    r.count = 5'(list_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < REPORT_CAP) begin
      $display("%0t ns: %s mismatch on result %0d: got %0d, expected %0d",
               $realtime, what, results_checked, got, want);
    end
    mismatch_count++;
  endtask

  // Sends one word. An optional gap with valid low comes first; once valid is up it
  // stays up with a steady payload until the block takes the word. The task returns
  // in the time step of acceptance, so the next word can follow back to back.
  task automatic send_word(input cmd_t cmd, input logic [7:0] ev, input logic [3:0] idx);
    int          gap;
    key_result_t want;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_event_code  <= ev;
    in_entry_index <= idx;
    do @(posedge clk); while (!in_ready);
    want = track_word(cmd, ev, idx);
    pending_results.insert(pending_results.size(), want);
    words_sent++;
  endtask

  // Holds the input off until every predicted word has come out. Valid is lowered
  // first and at least one edge passes, so a following send never lowers and raises
  // valid in the same time step.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // A read of an empty list, a pressed zero key code, and the spare command.
  task automatic test_empty_and_ignored();
    send_word(CMD_READ, 8'h00, 4'd0);
    send_word(CMD_KEY, 8'h80, 4'd15);
    send_word(CMD_NONE, 8'hFF, 4'd15);
  endtask

  // The highest key code (x = 25, y = 2) and a column-four key whose alias is used later.
  task automatic test_extremes();
    send_word(CMD_KEY, 8'hFF, 4'd0);
    send_word(CMD_KEY, 8'h85, 4'd0);
  endtask

  // Fills the list to capacity, then a new press is dropped, an aliased press of a
  // held key still reports held, a release from the middle closes the gap, a second
  // release finds nothing, the last entry is read back and the list is cleared.
  task automatic test_full_list();
    int added;
    added = 0;
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        if (added < LIST_DEPTH - 2) begin
          send_word(CMD_KEY, {1'b1, 7'(row * KEY_COLS + col + 1)}, 4'd0);
          added++;
        end
      end
    end
    send_word(CMD_KEY, 8'h80 | 8'd41, 4'd0);
    send_word(CMD_KEY, 8'h89, 4'd0);
    send_word(CMD_KEY, 8'h09, 4'd0);
    send_word(CMD_KEY, 8'h05, 4'd0);
    send_word(CMD_READ, 8'h00, 4'(LIST_DEPTH - 2));
    send_word(CMD_CLEAR, 8'h00, 4'd0);
    wait_for_results();
  endtask

  // Random traffic. Most key events are presses and releases of a modest key set, or of
  // keys already held (sometimes through their alias code), so the list fills, drains
  // and hits capacity. The press share swings between high and low every 60 words.
  task automatic test_random_traffic(input int words, input int gap_pct, input int stall_pct);
    cmd_t       cmd;
    logic [7:0] ev;
    logic [3:0] idx;
    logic [6:0] code;
    int         pick;
    int         press_pct;
    int         slot;
    int         row;
    int         col;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    press_pct = 80;
    for (int n = 0; n < words; n++) begin
      if (n % 60 == 59) press_pct = (press_pct == 80) ? 25 : 80;
      pick = $urandom_range(0, 199);
      ev = 8'($urandom);
      idx = 4'($urandom);
      if (pick < 3) begin
        cmd = CMD_CLEAR;
      end else if (pick < 9) begin
        cmd = CMD_NONE;
      end else if (pick < 70) begin
        cmd = CMD_READ;
        if (list_len > 0 && $urandom_range(0, 9) < 7) idx = 4'($urandom_range(0, list_len - 1));
      end else begin
        cmd = CMD_KEY;
        pick = $urandom_range(0, 99);
        if (list_len > 0 && pick < 40) begin
          // Turn a held entry back into a key code; columns four and five of the
          // lower rows may take their alias in columns eight and nine instead.
          slot = $urandom_range(0, list_len - 1);
          row = int'(list_x[slot]) / 2;
          col = (int'(list_x[slot]) % 2) * 4 + int'(list_y[slot]);
          if (row < 12 && col >= 4 && col <= 5 && $urandom_range(0, 1) == 1) col += 4;
          code = 7'(row * KEY_COLS + col + 1);
        end else if (pick < 80) begin
          code = 7'($urandom_range(1, 40));
        end else if (pick < 97) begin
          code = 7'($urandom_range(1, 127));
        end else begin
          code = '0;
        end
        ev = {1'($urandom_range(0, 99) < press_pct), code};
      end
      send_word(cmd, ev, idx);
      if (n % 100 == 99 && $urandom_range(0, 3) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // The receiver drops ready at random in the share of cycles set for the phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every result word taken at an edge is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    key_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, action", out_action, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_action !== want.action) report_mismatch("action", out_action, want.action);
        if (out_key_x !== want.key_x) report_mismatch("key_x", out_key_x, want.key_x);
        if (out_key_y !== want.key_y) report_mismatch("key_y", out_key_y, want.key_y);
        if (out_pressed !== want.pressed) report_mismatch("pressed", out_pressed, want.pressed);
        if (out_held_count !== want.count) begin
          report_mismatch("held_count", out_held_count, want.count);
        end
        if (out_entry_valid !== want.entry_valid) begin
          report_mismatch("entry_valid", out_entry_valid, want.entry_valid);
        end
        if (want.entry_valid) reads_in_list++;
      end
      action_seen[out_action]++;
      results_checked++;
    end
  end

  // The run is abandoned if neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("tb_key_event_decode_held_set_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words run with the first idling setting.
    send_gap_pct = 30;
    recv_stall_pct = 49;
    test_empty_and_ignored();
    test_extremes();
    test_full_list();

    // Random words in three phases: sender idling more lightly, then the receiver
    // idling more lightly, then both at full rate.
    test_random_traffic(400, 30, 49);
    test_random_traffic(400, 49, 30);
    test_random_traffic(400, 0, 0);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d words, checked %0d results: %0d added, %0d held, %0d removed,",
             words_sent, results_checked, action_seen[ACT_ADDED], action_seen[ACT_HELD],
             action_seen[ACT_REMOVED]);
    $display("  %0d not held, %0d full drops, %0d ignored, %0d clears, %0d reads (%0d in list).",
             action_seen[ACT_NOT_HELD], action_seen[ACT_FULL], action_seen[ACT_IGNORED],
             action_seen[ACT_CLEARED], action_seen[ACT_READ], reads_in_list);
    if (mismatch_count == 0) begin
      $display("tb_key_event_decode_held_set_top OK");
    end else begin
      $display("tb_key_event_decode_held_set_top NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/kedh_pkg.sv
hw/rtl/kedh_front.sv
hw/rtl/kedh_fifo.sv
hw/rtl/kedh_back.sv
hw/rtl/key_event_decode_held_set_top.sv
sim/tb_key_event_decode_held_set_top.sv
